// ----- sv/itp_pkg.sv -----
package itp_pkg;

	// Default operator stack depth
	localparam int ITP_STACK_DEPTH = 32;

	// Stack entry codes
	localparam int CODE_W = 3;
	typedef logic [CODE_W-1:0] op_code_t;

	localparam op_code_t OP_OPEN = 3'd0;
	localparam op_code_t OP_ADD  = 3'd1;
	localparam op_code_t OP_SUB  = 3'd2;
	localparam op_code_t OP_MUL  = 3'd3;
	localparam op_code_t OP_DIV  = 3'd4;
	localparam op_code_t OP_POW  = 3'd5;

	// ASCII characters with a meaning of their own
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	// Character classes
	typedef enum logic [2:0] {
		CLS_DROP,
		CLS_ALNUM,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OP
	} char_cls_t;

	typedef struct packed {
		char_cls_t cls;
		op_code_t  code;
	} char_info_t;

	// Stack code back to its ASCII character
	function automatic logic [7:0] code_char(op_code_t c);
		logic [7:0] ch;
		unique case (c)
			OP_OPEN: ch = CH_LPAR;
			OP_ADD:  ch = CH_PLUS;
			OP_SUB:  ch = CH_MINUS;
			OP_MUL:  ch = CH_STAR;
			OP_DIV:  ch = CH_SLASH;
			OP_POW:  ch = CH_CARET;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Precedence; open parenthesis ranks lowest
	function automatic logic [1:0] code_prec(op_code_t c);
		logic [1:0] p;
		unique case (c)
			OP_ADD, OP_SUB: p = 2'd1;
			OP_MUL, OP_DIV: p = 2'd2;
			OP_POW:         p = 2'd3;
			default:        p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

// ----- sv/infix_to_postfix_converter.sv -----
// Channel   Dir  Request contents
// s_axis    in   tdata[7:0] character; tuser[0] kind (1 = end of expression)
// m_axis    out  tdata[7:0] symbol; tuser[0] done_res, tuser[1] error; tlast = last
//
// A letter or digit is handed out through the single-result state; an open parenthesis
// or a dropped character is handled on accept. Each stacked entry popped by a close
// parenthesis, an operator or the end mark passes a stack RAM read and the precedence
// compare before the item finishes. Output stalls hold the sequencer; one result is
// buffered so the last flag is known before it is presented.
// arst_n clears the sequencer, stack count and error flag; the stack RAM is not cleared.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = itp_pkg::ITP_STACK_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] character
	input  logic [0:0] s_axis_tuser,  // [0] kind
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] symbol
	output logic [1:0] m_axis_tuser,  // [0] done_res, [1] error
	output logic       m_axis_tlast
);

	import itp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_SINGLE
	} state_t;

	typedef enum logic [1:0] {
		M_CLOSE,
		M_OP,
		M_DRAIN
	} mode_t;

	state_t     state_q;
	mode_t      mode_q;
	op_code_t   op_q;
	logic [CW-1:0] count_q;
	logic       err_q;
	logic       err_acc_q;
	logic       pend_vld_q;
	logic [7:0] pend_sym_q;
	logic       pend_done_q;
	logic       pend_err_q;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic [1:0] m_tuser_q;
	logic       m_tlast_q;

	char_info_t info;
	op_code_t   top_code;
	logic       empty;
	logic       full;
	logic       out_free;
	logic       out_load;
	logic       pop_want;
	logic       pop_emits;
	logic       accept;
	logic       wr_en;
	op_code_t   wr_data;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] count_dec;

	itp_classify u_classify (
		.character (s_axis_tdata),
		.info      (info)
	);

	itp_ram #(
		.WIDTH (CODE_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (top_code)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;
	assign m_axis_tlast  = m_tlast_q;

	// Stack pointers and status
	assign count_dec = count_q - CW'(1);
	assign rd_addr   = count_dec[AW-1:0];
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign out_free  = !m_tvalid_q || m_axis_tready;

	// Output register takes the buffered result this cycle
	assign out_load = out_free && ((state_q == ST_SINGLE) ||
		(state_q == ST_SCAN && pend_vld_q &&
			(pop_want ? pop_emits : (mode_q == M_DRAIN))));

	// Shared pop decision: one stack entry per pass
	always_comb begin
		unique case (mode_q)
			M_CLOSE: pop_want = !empty && (top_code != OP_OPEN);
			M_OP:    pop_want = !empty && (code_prec(top_code) >= code_prec(op_q));
			M_DRAIN: pop_want = !empty;
			default: pop_want = 1'b0;
		endcase
		pop_emits = !((mode_q == M_DRAIN) && (top_code == OP_OPEN));
	end

	// Stack push: open parenthesis on accept, operator at end of its scan
	always_comb begin
		wr_en   = 1'b0;
		wr_data = OP_OPEN;
		if (accept && !s_axis_tuser[0] && !err_q && info.cls == CLS_OPEN && !full) begin
			wr_en = 1'b1;
		end else if (state_q == ST_SCAN && mode_q == M_OP && !pop_want && !full) begin
			wr_en   = 1'b1;
			wr_data = op_q;
		end
	end

	// Sequencer, stack count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= M_DRAIN;
			op_q        <= OP_OPEN;
			count_q     <= '0;
			err_q       <= 1'b0;
			err_acc_q   <= 1'b0;
			pend_vld_q  <= 1'b0;
			pend_sym_q  <= 8'h00;
			pend_done_q <= 1'b0;
			pend_err_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= 8'h00;
			m_tuser_q   <= 2'b00;
			m_tlast_q   <= 1'b0;
		end else begin
			// Output valid: set on a load, cleared when the request is taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (s_axis_tuser[0]) begin
							if (err_q) begin
								pend_vld_q  <= 1'b1;
								pend_sym_q  <= 8'h00;
								pend_done_q <= 1'b1;
								pend_err_q  <= 1'b1;
								count_q     <= '0;
								err_q       <= 1'b0;
								state_q     <= ST_SINGLE;
							end else begin
								mode_q    <= M_DRAIN;
								err_acc_q <= 1'b0;
								state_q   <= ST_SCAN;
							end
						end else if (!err_q) begin
							unique case (info.cls)
								CLS_ALNUM: begin
									pend_vld_q  <= 1'b1;
									pend_sym_q  <= s_axis_tdata;
									pend_done_q <= 1'b0;
									pend_err_q  <= 1'b0;
									state_q     <= ST_SINGLE;
								end
								CLS_OPEN: begin
									if (full) begin
										err_q <= 1'b1;
									end else begin
										count_q <= count_q + CW'(1);
									end
								end
								CLS_CLOSE: begin
									mode_q  <= M_CLOSE;
									state_q <= ST_SCAN;
								end
								CLS_OP: begin
									mode_q  <= M_OP;
									op_q    <= info.code;
									state_q <= ST_SCAN;
								end
								default: begin
								end
							endcase
						end
					end
				end
				ST_SCAN: begin
					if (pop_want) begin
						if (!pop_emits) begin
							// open parenthesis left at the end mark
							err_acc_q <= 1'b1;
							count_q   <= count_dec;
							state_q   <= ST_FETCH;
						end else if (!pend_vld_q || out_free) begin
							if (pend_vld_q) begin
								m_tdata_q  <= pend_sym_q;
								m_tuser_q  <= {pend_err_q, pend_done_q};
								m_tlast_q  <= 1'b0;
							end
							pend_vld_q  <= 1'b1;
							pend_sym_q  <= code_char(top_code);
							pend_done_q <= 1'b0;
							pend_err_q  <= 1'b0;
							count_q     <= count_dec;
							state_q     <= ST_FETCH;
						end
					end else begin
						unique case (mode_q)
							M_CLOSE: begin
								if (empty) begin
									err_q <= 1'b1;
								end else begin
									count_q <= count_dec;
								end
								state_q <= pend_vld_q ? ST_SINGLE : ST_IDLE;
							end
							M_OP: begin
								if (full) begin
									err_q <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
								end
								state_q <= pend_vld_q ? ST_SINGLE : ST_IDLE;
							end
							M_DRAIN: begin
								if (!pend_vld_q || out_free) begin
									if (pend_vld_q) begin
										m_tdata_q  <= pend_sym_q;
										m_tuser_q  <= {pend_err_q, pend_done_q};
										m_tlast_q  <= 1'b0;
									end
									pend_vld_q  <= 1'b1;
									pend_sym_q  <= 8'h00;
									pend_done_q <= 1'b1;
									pend_err_q  <= err_acc_q;
									count_q     <= '0;
									err_q       <= 1'b0;
									state_q     <= ST_SINGLE;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_FETCH: begin
					// new top of stack arrives from the RAM
					state_q <= ST_SCAN;
				end
				ST_SINGLE: begin
					if (out_free) begin
						m_tdata_q  <= pend_sym_q;
						m_tuser_q  <= {pend_err_q, pend_done_q};
						m_tlast_q  <= 1'b1;
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/itp_ram.sv -----
module itp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/itp_classify.sv -----
module itp_classify (
	input  logic [7:0]          character,
	output itp_pkg::char_info_t info
);

	import itp_pkg::*;

	// Sort one character into its class and operator code
	always_comb begin
		info.cls  = CLS_DROP;
		info.code = OP_OPEN;
		priority if ((character >= CH_0 && character <= CH_9) ||
				(character >= CH_UA && character <= CH_UZ) ||
				(character >= CH_LA && character <= CH_LZ)) begin
			info.cls = CLS_ALNUM;
		end else if (character == CH_LPAR) begin
			info.cls = CLS_OPEN;
		end else if (character == CH_RPAR) begin
			info.cls = CLS_CLOSE;
		end else if (character == CH_PLUS) begin
			info.cls  = CLS_OP;
			info.code = OP_ADD;
		end else if (character == CH_MINUS) begin
			info.cls  = CLS_OP;
			info.code = OP_SUB;
		end else if (character == CH_STAR) begin
			info.cls  = CLS_OP;
			info.code = OP_MUL;
		end else if (character == CH_SLASH) begin
			info.cls  = CLS_OP;
			info.code = OP_DIV;
		end else if (character == CH_CARET) begin
			info.cls  = CLS_OP;
			info.code = OP_POW;
		end else begin
			info.cls = CLS_DROP;
		end
	end

endmodule

// ----- sv/itp_checker.sv -----
module itp_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [0:0] s_axis_tuser,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// Stalled result holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("stalled result changed");

	// Error only on a done result
	a_err_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
		else $error("error flag without done");

	// Done result carries a zero symbol and closes the request
	a_done_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == 8'h00) && m_axis_tlast)
		else $error("malformed done result");

	// Ordinary results are never a zero symbol
	a_sym_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata != 8'h00))
		else $error("zero symbol on ordinary result");

	// An end mark always keeps the input busy for the next cycle
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
		else $error("input ready right after end mark");

endmodule

bind infix_to_postfix_converter itp_port_checker u_itp_checker (.*);
